// ===== rtl/i2csme_pkg.sv =====
// Shared types and constants for the I2C slave message engine.
// Used by i2csme_front, i2csme_back and i2c_slave_message_engine.
`default_nettype none
package i2csme_pkg;

    localparam int MSG_DEPTH = 32;
    localparam int ADDR_W    = $clog2(MSG_DEPTH);
    localparam int LEN_W     = ADDR_W + 1;
    localparam int TOO_LONG  = MSG_DEPTH - 2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_MSG    = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;
    localparam logic [1:0] KIND_REQ    = 2'd3;

    localparam logic [1:0] ERR_OVERRUN = 2'd0;
    localparam logic [1:0] ERR_NOADDR  = 2'd1;
    localparam logic [1:0] ERR_NODATA  = 2'd2;
    localparam logic [1:0] ERR_TOOLONG = 2'd3;

    // one job handed from the front end to the back end
    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             release_clock;
        logic             has_msg;
        logic [LEN_W-1:0] msg_len;
        logic             has_err;
        logic [7:0]       err_count;
        logic [1:0]       err_code;
        logic [7:0]       err_events;
        logic             has_req;
    } job_t;

    // receive store write port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } rx_wr_t;

endpackage
`default_nettype wire

// ===== rtl/i2csme_front.sv =====
// Front end: accepts items, runs the bus status machine, owns the transmit store.
// Depends on i2csme_pkg.
`default_nettype none
module i2csme_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        accept_ok,
    input  wire logic                   back_idle,
    input  wire logic                   cfg_we,
    input  wire logic [7:0]             cfg_wdata,
    input  wire logic                   cmd,
    input  wire logic                   start_seen,
    input  wire logic                   stop_seen,
    input  wire logic                   byte_present,
    input  wire logic                   overrun,
    input  wire logic                   is_data,
    input  wire logic                   is_read,
    input  wire logic [7:0]             byte_in,
    input  wire logic                   reply_last,
    output i2csme_pkg::rx_wr_t          rx_wr,
    output logic                        job_valid,
    output i2csme_pkg::job_t            job,
    input  wire logic                   job_take
);

    typedef enum logic [1:0] {F_IDLE, F_EXEC, F_POST} fstate_t;
    typedef enum logic [1:0] {ST_IDLE, ST_STARTED, ST_RCV, ST_SEND} bus_t;

    localparam int AW = i2csme_pkg::ADDR_W;
    localparam int LW = i2csme_pkg::LEN_W;

    fstate_t          fstate_reg;
    bus_t             bus_reg, bus_next;
    logic [7:0]       thr_reg;
    logic [LW-1:0]    rx_len_reg, rx_len_next;
    logic [7:0]       ev_reg, ev_next;
    logic [7:0]       erc_reg, erc_next;
    logic [1:0]       le_reg, le_next;
    logic [LW-1:0]    tx_len_reg, tx_len_next;
    logic [LW-1:0]    tx_idx_reg, tx_idx_next;
    logic             ready_reg;
    logic             job_valid_reg;
    i2csme_pkg::job_t job_reg, job_next;

    // latched item
    logic       cmd_reg, start_reg, stop_reg, pres_reg, ovr_reg, data_reg, rd_reg, rlast_reg;
    logic [7:0] b_reg;

    logic [7:0]    tx_mem [i2csme_pkg::MSG_DEPTH];
    logic [7:0]    tx_rd_reg;
    logic [AW-1:0] tx_ra;
    logic          tx_we;
    logic [AW-1:0] tx_wa;
    logic          ready_next;
    logic          take_item;
    i2csme_pkg::rx_wr_t rx_exec;

    assign accept_ok = (fstate_reg == F_IDLE) && !job_valid_reg && back_idle;
    assign take_item = push && accept_ok;
    assign tx_ra     = cmd ? '0 : tx_idx_reg[AW-1:0];
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_ff @(posedge clk)
    begin
        if (tx_we && fstate_reg == F_EXEC)
        begin
            tx_mem[tx_wa] <= b_reg;
        end
        tx_rd_reg <= tx_mem[tx_ra];
    end

    always_comb
    begin
        logic got;
        logic wrote;
        logic req;
        logic [7:0] txb;
        logic txv;
        logic rel;
        got         = pres_reg;
        wrote       = 1'b0;
        req         = 1'b0;
        txb         = 8'd0;
        txv         = 1'b0;
        rel         = 1'b0;
        bus_next    = bus_reg;
        rx_len_next = rx_len_reg;
        ev_next     = ev_reg;
        erc_next    = erc_reg;
        le_next     = le_reg;
        tx_len_next = tx_len_reg;
        tx_idx_next = tx_idx_reg;
        ready_next  = 1'b0;
        tx_we       = 1'b0;
        tx_wa       = '0;
        rx_exec     = '{we: 1'b0, addr: rx_len_reg[AW-1:0], data: b_reg};
        job_next    = '0;

        if (cmd_reg)
        begin
            if (tx_idx_reg != '0)
            begin
                tx_len_next = '0;
                tx_idx_next = '0;
            end
            if (tx_len_next < LW'(i2csme_pkg::MSG_DEPTH))
            begin
                tx_we       = 1'b1;
                tx_wa       = tx_len_next[AW-1:0];
                tx_len_next = tx_len_next + 1'b1;
            end
            if (rlast_reg)
            begin
                tx_idx_next = LW'(1);
                txv = 1'b1;
                rel = 1'b1;
                txb = (tx_we && tx_wa == '0) ? b_reg : tx_rd_reg;
            end
            job_next.tx_valid      = txv;
            job_next.tx_byte       = txb;
            job_next.release_clock = rel;
        end
        else
        begin
            if (ovr_reg)
            begin
                bus_next = ST_IDLE;
                erc_next = erc_next + 8'd1;
                le_next  = i2csme_pkg::ERR_OVERRUN;
            end
            else
            begin
                case (bus_reg)
                    ST_IDLE:
                    begin
                        if (start_reg)
                        begin
                            ev_next     = 8'd1;
                            rx_len_next = '0;
                            if (!got)
                            begin
                                bus_next = ST_STARTED;
                            end
                            else if (data_reg)
                            begin
                                bus_next = ST_IDLE;
                                erc_next = erc_next + 8'd1;
                                le_next  = i2csme_pkg::ERR_NOADDR;
                            end
                            else if (rd_reg)
                            begin
                                bus_next = ST_SEND;
                                got = 1'b0;
                                req = 1'b1;
                            end
                            else
                            begin
                                bus_next = ST_RCV;
                            end
                        end
                    end
                    ST_STARTED:
                    begin
                        if (stop_reg)
                        begin
                            ev_next = ev_next + 8'd1;
                            if (got)
                            begin
                                if (!data_reg)
                                begin
                                    ready_next = 1'b1;
                                end
                                else
                                begin
                                    erc_next = erc_next + 8'd1;
                                    le_next  = i2csme_pkg::ERR_NODATA;
                                end
                            end
                            bus_next = ST_IDLE;
                        end
                        else if (got)
                        begin
                            ev_next = ev_next + 8'd1;
                            if (data_reg)
                            begin
                                erc_next = erc_next + 8'd1;
                                le_next  = i2csme_pkg::ERR_NODATA;
                                bus_next = ST_IDLE;
                            end
                            else if (rd_reg)
                            begin
                                bus_next = ST_SEND;
                                req = 1'b1;
                                got = 1'b0;
                            end
                            else
                            begin
                                bus_next = ST_RCV;
                            end
                        end
                    end
                    ST_SEND:
                    begin
                        if (tx_idx_reg < tx_len_reg
                            && tx_idx_reg < LW'(i2csme_pkg::MSG_DEPTH))
                        begin
                            txb         = tx_rd_reg;
                            tx_idx_next = tx_idx_reg + 1'b1;
                            wrote       = 1'b1;
                        end
                        else
                        begin
                            bus_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (stop_reg)
                        begin
                            ev_next = ev_next + 8'd1;
                            if (!got || data_reg)
                            begin
                                if (got && rx_len_reg < LW'(i2csme_pkg::MSG_DEPTH))
                                begin
                                    rx_exec.we  = 1'b1;
                                    rx_len_next = rx_len_reg + 1'b1;
                                end
                                ready_next = 1'b1;
                            end
                            else
                            begin
                                erc_next = erc_next + 8'd1;
                                le_next  = i2csme_pkg::ERR_NODATA;
                            end
                            bus_next = ST_IDLE;
                        end
                        else if (got)
                        begin
                            ev_next = ev_next + 8'd1;
                            if (data_reg)
                            begin
                                if (rx_len_reg < LW'(i2csme_pkg::MSG_DEPTH))
                                begin
                                    rx_exec.we  = 1'b1;
                                    rx_len_next = rx_len_reg + 1'b1;
                                end
                            end
                            else if (rd_reg)
                            begin
                                bus_next   = ST_SEND;
                                ready_next = 1'b1;
                                req        = 1'b1;
                                got        = 1'b0;
                            end
                            else
                            begin
                                erc_next = erc_next + 8'd1;
                                le_next  = i2csme_pkg::ERR_NODATA;
                                bus_next = ST_IDLE;
                            end
                        end
                    end
                endcase
            end

            job_next.tx_valid      = wrote;
            job_next.tx_byte       = txb;
            job_next.release_clock = got || wrote;

            if (!ready_next && rx_len_next > LW'(i2csme_pkg::TOO_LONG))
            begin
                bus_next = ST_IDLE;
                erc_next = erc_next + 8'd1;
                le_next  = i2csme_pkg::ERR_TOOLONG;
            end

            job_next.has_msg = ready_next;
            if (!ready_next && erc_next >= thr_reg)
            begin
                job_next.has_err    = 1'b1;
                job_next.err_count  = erc_next;
                job_next.err_code   = le_next;
                job_next.err_events = ev_next;
                erc_next            = 8'd0;
            end
            job_next.has_req = req;
        end
    end

    // event count goes in after the last data byte
    always_comb
    begin
        rx_wr = rx_exec;
        if (fstate_reg == F_POST)
        begin
            rx_wr.we   = ready_reg && rx_len_reg < LW'(i2csme_pkg::MSG_DEPTH);
            rx_wr.addr = rx_len_reg[AW-1:0];
            rx_wr.data = ev_reg;
        end
        else if (fstate_reg != F_EXEC)
        begin
            rx_wr.we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            cmd_reg   <= cmd;
            start_reg <= start_seen;
            stop_reg  <= stop_seen;
            pres_reg  <= byte_present;
            ovr_reg   <= overrun;
            data_reg  <= is_data;
            rd_reg    <= is_read;
            b_reg     <= byte_in;
            rlast_reg <= reply_last;
        end
        if (fstate_reg == F_EXEC)
        begin
            job_reg <= job_next;
        end
        else if (fstate_reg == F_POST && ready_reg)
        begin
            job_reg.msg_len <= (rx_len_reg < LW'(i2csme_pkg::MSG_DEPTH))
                               ? rx_len_reg + 1'b1 : rx_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fstate_reg    <= F_IDLE;
            bus_reg       <= ST_IDLE;
            thr_reg       <= 8'd1;
            rx_len_reg    <= '0;
            ev_reg        <= 8'd0;
            erc_reg       <= 8'd0;
            le_reg        <= 2'd0;
            tx_len_reg    <= '0;
            tx_idx_reg    <= '0;
            ready_reg     <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (job_take)
            begin
                job_valid_reg <= 1'b0;
            end
            case (fstate_reg)
                F_IDLE:
                begin
                    if (take_item)
                    begin
                        fstate_reg <= F_EXEC;
                    end
                end
                F_EXEC:
                begin
                    bus_reg    <= bus_next;
                    rx_len_reg <= rx_len_next;
                    ev_reg     <= ev_next;
                    erc_reg    <= erc_next;
                    le_reg     <= le_next;
                    tx_len_reg <= tx_len_next;
                    tx_idx_reg <= tx_idx_next;
                    ready_reg  <= ready_next;
                    fstate_reg <= F_POST;
                end
                F_POST:
                begin
                    if (ready_reg)
                    begin
                        rx_len_reg <= '0;
                    end
                    job_valid_reg <= 1'b1;
                    fstate_reg    <= F_IDLE;
                end
                default:
                begin
                    fstate_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/i2csme_back.sv =====
// Back end: owns the receive store and emits the result items of one job.
// Depends on i2csme_pkg.
`default_nettype none
module i2csme_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire i2csme_pkg::rx_wr_t rx_wr,
    input  wire logic               job_valid,
    input  wire i2csme_pkg::job_t   job,
    output logic                    job_take,
    output logic                    idle,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              kind,
    output logic [7:0]              byte_out,
    output logic                    tx_valid,
    output logic [7:0]              tx_byte,
    output logic                    release_clock,
    output logic                    last
);

    typedef enum logic [2:0] {B_IDLE, B_STATUS, B_MSG, B_ERR, B_REQ} bstate_t;

    localparam int AW = i2csme_pkg::ADDR_W;
    localparam int LW = i2csme_pkg::LEN_W;

    bstate_t          st_reg, st_next;
    i2csme_pkg::job_t job_reg;
    logic [LW-1:0]    idx_reg, idx_next;
    logic [7:0]       rx_mem [i2csme_pkg::MSG_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             slot_free, emit;
    logic [1:0]       kind_n;
    logic [7:0]       byte_n;
    logic             last_n;

    logic             out_valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       byte_reg;
    logic             txv_reg;
    logic [7:0]       txb_reg;
    logic             rel_reg;
    logic             last_reg;

    assign idle      = (st_reg == B_IDLE);
    assign job_take  = idle && job_valid;
    assign slot_free = !out_valid_reg || pop;
    assign emit      = slot_free && !idle;

    always_ff @(posedge clk)
    begin
        if (rx_wr.we)
        begin
            rx_mem[rx_wr.addr] <= rx_wr.data;
        end
        rd_data_reg <= rx_mem[idx_next[AW-1:0]];
    end

    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        kind_n   = i2csme_pkg::KIND_STATUS;
        byte_n   = 8'd0;
        last_n   = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                idx_next = '0;
                if (job_valid)
                begin
                    st_next = B_STATUS;
                end
            end
            B_STATUS:
            begin
                last_n = !(job_reg.has_msg || job_reg.has_err || job_reg.has_req);
                if (emit)
                begin
                    idx_next = '0;
                    if (job_reg.has_msg)
                    begin
                        st_next = B_MSG;
                    end
                    else if (job_reg.has_err)
                    begin
                        st_next = B_ERR;
                    end
                    else if (job_reg.has_req)
                    begin
                        st_next = B_REQ;
                    end
                    else
                    begin
                        st_next = B_IDLE;
                    end
                end
            end
            B_MSG:
            begin
                kind_n = i2csme_pkg::KIND_MSG;
                byte_n = rd_data_reg;
                last_n = (idx_reg == job_reg.msg_len - 1'b1) && !job_reg.has_req;
                if (emit)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == job_reg.msg_len - 1'b1)
                    begin
                        st_next = job_reg.has_req ? B_REQ : B_IDLE;
                    end
                end
            end
            B_ERR:
            begin
                kind_n = i2csme_pkg::KIND_ERR;
                case (idx_reg[1:0])
                    2'd0:    byte_n = job_reg.err_count;
                    2'd1:    byte_n = {6'd0, job_reg.err_code};
                    default: byte_n = job_reg.err_events;
                endcase
                last_n = (idx_reg[1:0] == 2'd2) && !job_reg.has_req;
                if (emit)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg[1:0] == 2'd2)
                    begin
                        st_next = job_reg.has_req ? B_REQ : B_IDLE;
                    end
                end
            end
            B_REQ:
            begin
                kind_n = i2csme_pkg::KIND_REQ;
                last_n = 1'b1;
                if (emit)
                begin
                    st_next = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            kind_reg <= kind_n;
            byte_reg <= byte_n;
            txv_reg  <= (st_reg == B_STATUS) && job_reg.tx_valid;
            txb_reg  <= (st_reg == B_STATUS) ? job_reg.tx_byte : 8'd0;
            rel_reg  <= (st_reg == B_STATUS) && job_reg.release_clock;
            last_reg <= last_n;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty         = !out_valid_reg;
    assign kind          = kind_reg;
    assign byte_out      = byte_reg;
    assign tx_valid      = txv_reg;
    assign tx_byte       = txb_reg;
    assign release_clock = rel_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

// ===== rtl/i2c_slave_message_engine.sv =====
// I2C slave message engine, top level: front end, one-entry job queue, back end.
// Path: item latch, front-end EXEC and POST states, job register, back-end status
// state, output registers. Throughput: the back end emits one result item per
// cycle while pop keeps up; a new item is taken only when the front end is idle,
// the job queue is empty and the back end is idle. Items are taken one at a time.
// Reset: rst_n async low; bus idle, counters and lengths zero, threshold 1.
`default_nettype none
module i2c_slave_message_engine (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       cmd,
    input  wire logic       start_seen,
    input  wire logic       stop_seen,
    input  wire logic       byte_present,
    input  wire logic       overrun,
    input  wire logic       is_data,
    input  wire logic       is_read,
    input  wire logic [7:0] byte_in,
    input  wire logic       reply_last,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      kind,
    output logic [7:0]      byte_out,
    output logic            tx_valid,
    output logic [7:0]      tx_byte,
    output logic            release_clock,
    output logic            last,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    logic               accept_ok;
    logic               back_idle;
    logic               job_valid;
    logic               job_take;
    i2csme_pkg::job_t   job;
    i2csme_pkg::rx_wr_t rx_wr;

    // full while an item is still in the front end or job queue, or the back end is busy
    assign full = !accept_ok;

    i2csme_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .accept_ok    (accept_ok),
        .back_idle    (back_idle),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .start_seen   (start_seen),
        .stop_seen    (stop_seen),
        .byte_present (byte_present),
        .overrun      (overrun),
        .is_data      (is_data),
        .is_read      (is_read),
        .byte_in      (byte_in),
        .reply_last   (reply_last),
        .rx_wr        (rx_wr),
        .job_valid    (job_valid),
        .job          (job),
        .job_take     (job_take)
    );

    // back end drains the job into status, message, report and request items
    i2csme_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_wr         (rx_wr),
        .job_valid     (job_valid),
        .job           (job),
        .job_take      (job_take),
        .idle          (back_idle),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .byte_out      (byte_out),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .release_clock (release_clock),
        .last          (last)
    );

endmodule
`default_nettype wire

// ===== tb/tb_i2c_slave_message_engine.sv =====
// Self-checking testbench for i2c_slave_message_engine: directed table, then random
// bus transactions and reply loads, checked against an in-bench behavioral predictor.
// Depends on i2csme_pkg and the RTL of the engine only.
`timescale 1ns / 1ps
`default_nettype none
module tb_i2c_slave_message_engine;

    // bus status as the predictor tracks it
    typedef enum logic [1:0] {BUS_IDLE, BUS_STARTED, BUS_RCV, BUS_SEND} bus_t;

    typedef struct packed {
        logic       cmd;
        logic       start_seen;
        logic       stop_seen;
        logic       byte_present;
        logic       overrun;
        logic       is_data;
        logic       is_read;
        logic [7:0] byte_in;
        logic       reply_last;
    } msg_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       release_clock;
        logic       last;
    } res_item_t;

    typedef struct {
        msg_item_t it;
        logic      chk;     // typed status below is checked
        res_item_t status;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       cmd = 1'b0;
    logic       start_seen = 1'b0;
    logic       stop_seen = 1'b0;
    logic       byte_present = 1'b0;
    logic       overrun = 1'b0;
    logic       is_data = 1'b0;
    logic       is_read = 1'b0;
    logic [7:0] byte_in = 8'h00;
    logic       reply_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       release_clock;
    logic       last;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;

    i2c_slave_message_engine u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .start_seen(start_seen), .stop_seen(stop_seen), .byte_present(byte_present),
        .overrun(overrun), .is_data(is_data), .is_read(is_read), .byte_in(byte_in),
        .reply_last(reply_last), .empty(empty), .pop(pop), .kind(kind),
        .byte_out(byte_out), .tx_valid(tx_valid), .tx_byte(tx_byte),
        .release_clock(release_clock), .last(last), .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state, mirrors the engine after reset
    bus_t       m_bus = BUS_IDLE;
    logic [7:0] m_rx_mem [i2csme_pkg::MSG_DEPTH];
    int         m_rx_len = 0;
    logic [7:0] m_events = 8'd0;
    logic [7:0] m_errs = 8'd0;
    logic [1:0] m_last_err = i2csme_pkg::ERR_OVERRUN;
    logic [7:0] m_tx_mem [i2csme_pkg::MSG_DEPTH];
    int         m_tx_len = 0;
    int         m_tx_idx = 0;
    logic [7:0] m_thresh = 8'd1;

    res_item_t  expected_q[$];
    res_item_t  pred_status;      // status item of the latest accepted item
    res_item_t  typed_status;
    logic       steady = 1'b0;    // no idling on either side while set
    int         n_err = 0;
    int         n_items = 0;
    int         n_kind[4] = '{0, 0, 0, 0};
    int         quiet_cycles = 0;

    function automatic void expect_item(logic [1:0] k, logic [7:0] b, logic txv,
                                        logic [7:0] txb, logic rel);
        res_item_t r;
        r = '{kind: k, byte_out: b, tx_valid: txv, tx_byte: txb,
              release_clock: rel, last: 1'b0};
        expected_q.push_back(r);
    endfunction

    function automatic void count_error(logic [1:0] code);
        m_errs = m_errs + 8'd1;
        m_last_err = code;
    endfunction

    // work out every result item that one accepted item causes
    function automatic void predict_results(msg_item_t it);
        logic       got;
        logic       ready;
        logic       request;
        logic       wrote;
        logic [7:0] txb;
        int         base;
        base = expected_q.size();
        got = 1'b0;
        ready = 1'b0;
        request = 1'b0;
        wrote = 1'b0;
        txb = 8'h00;
        if (it.cmd)
        begin
            // reply load: a load after transmission began starts a new one
            if (m_tx_idx != 0)
            begin
                m_tx_len = 0;
                m_tx_idx = 0;
            end
            if (m_tx_len < i2csme_pkg::MSG_DEPTH)
            begin
                m_tx_mem[m_tx_len] = it.byte_in;
                m_tx_len++;
            end
            if (it.reply_last)
            begin
                m_tx_idx = 1;
                expect_item(i2csme_pkg::KIND_STATUS, 8'h00, 1'b1, m_tx_mem[0], 1'b1);
            end
            else
                expect_item(i2csme_pkg::KIND_STATUS, 8'h00, 1'b0, 8'h00, 1'b0);
        end
        else
        begin
            if (it.overrun)
            begin
                m_bus = BUS_IDLE;
                count_error(i2csme_pkg::ERR_OVERRUN);
            end
            got = it.byte_present;
            if (!it.overrun)
            begin
                case (m_bus)
                    BUS_IDLE:
                        if (it.start_seen)
                        begin
                            m_events = 8'd1;
                            m_rx_len = 0;
                            if (!got)
                                m_bus = BUS_STARTED;
                            else if (it.is_data)
                            begin
                                m_bus = BUS_IDLE;
                                count_error(i2csme_pkg::ERR_NOADDR);
                            end
                            else if (it.is_read)
                            begin
                                m_bus = BUS_SEND;
                                got = 1'b0;
                                request = 1'b1;
                            end
                            else
                                m_bus = BUS_RCV;
                        end
                    BUS_STARTED:
                        if (it.stop_seen)
                        begin
                            m_events = m_events + 8'd1;
                            if (got)
                            begin
                                if (!it.is_data)
                                    ready = 1'b1;
                                else
                                    count_error(i2csme_pkg::ERR_NODATA);
                            end
                            m_bus = BUS_IDLE;
                        end
                        else if (got)
                        begin
                            m_events = m_events + 8'd1;
                            if (it.is_data)
                            begin
                                count_error(i2csme_pkg::ERR_NODATA);
                                m_bus = BUS_IDLE;
                            end
                            else if (it.is_read)
                            begin
                                m_bus = BUS_SEND;
                                request = 1'b1;
                                got = 1'b0;
                            end
                            else
                                m_bus = BUS_RCV;
                        end
                    BUS_SEND:
                        if (m_tx_idx < m_tx_len && m_tx_idx < i2csme_pkg::MSG_DEPTH)
                        begin
                            txb = m_tx_mem[m_tx_idx];
                            m_tx_idx++;
                            wrote = 1'b1;
                        end
                        else
                            m_bus = BUS_IDLE;
                    default:
                        if (it.stop_seen)
                        begin
                            m_events = m_events + 8'd1;
                            if (!got || it.is_data)
                            begin
                                if (got && m_rx_len < i2csme_pkg::MSG_DEPTH)
                                begin
                                    m_rx_mem[m_rx_len] = it.byte_in;
                                    m_rx_len++;
                                end
                                ready = 1'b1;
                            end
                            else
                                count_error(i2csme_pkg::ERR_NODATA);
                            m_bus = BUS_IDLE;
                        end
                        else if (got)
                        begin
                            m_events = m_events + 8'd1;
                            if (it.is_data)
                            begin
                                if (m_rx_len < i2csme_pkg::MSG_DEPTH)
                                begin
                                    m_rx_mem[m_rx_len] = it.byte_in;
                                    m_rx_len++;
                                end
                            end
                            else if (it.is_read)
                            begin
                                m_bus = BUS_SEND;
                                ready = 1'b1;
                                request = 1'b1;
                                got = 1'b0;
                            end
                            else
                            begin
                                count_error(i2csme_pkg::ERR_NODATA);
                                m_bus = BUS_IDLE;
                            end
                        end
                endcase
            end
            expect_item(i2csme_pkg::KIND_STATUS, 8'h00, wrote, txb, got | wrote);

            // too-long message keeps erroring on every event until a start
            if (!ready && m_rx_len > i2csme_pkg::TOO_LONG)
            begin
                m_bus = BUS_IDLE;
                count_error(i2csme_pkg::ERR_TOOLONG);
            end

            if (ready)
            begin
                if (m_rx_len < i2csme_pkg::MSG_DEPTH)
                begin
                    m_rx_mem[m_rx_len] = m_events;
                    m_rx_len++;
                end
                for (int i = 0; i < m_rx_len && i < i2csme_pkg::MSG_DEPTH; i++)
                    expect_item(i2csme_pkg::KIND_MSG, m_rx_mem[i], 1'b0, 8'h00, 1'b0);
                m_rx_len = 0;
            end
            else if (m_errs >= m_thresh)
            begin
                expect_item(i2csme_pkg::KIND_ERR, m_errs, 1'b0, 8'h00, 1'b0);
                expect_item(i2csme_pkg::KIND_ERR, {6'd0, m_last_err}, 1'b0, 8'h00, 1'b0);
                expect_item(i2csme_pkg::KIND_ERR, m_events, 1'b0, 8'h00, 1'b0);
                m_errs = 8'd0;
            end
            if (request)
                expect_item(i2csme_pkg::KIND_REQ, 8'h00, 1'b0, 8'h00, 1'b0);
        end
        expected_q[expected_q.size() - 1].last = 1'b1;
        pred_status = expected_q[base];
    endfunction

    // result side: random pop (constant while steady), compare each popped item with the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= steady || ($urandom_range(99) >= 24);
    end

    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item kind %0d byte_out %02h", $time,
                         kind, byte_out);
                n_err++;
            end
            else
            begin
                want = expected_q.pop_front();
                n_kind[kind]++;
                if (kind !== want.kind)
                begin
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, kind);
                    n_err++;
                end
                if (byte_out !== want.byte_out)
                begin
                    $display("%0t: byte_out exp %02h got %02h", $time,
                             want.byte_out, byte_out);
                    n_err++;
                end
                if (tx_valid !== want.tx_valid)
                begin
                    $display("%0t: tx_valid exp %0b got %0b", $time,
                             want.tx_valid, tx_valid);
                    n_err++;
                end
                if (tx_byte !== want.tx_byte)
                begin
                    $display("%0t: tx_byte exp %02h got %02h", $time,
                             want.tx_byte, tx_byte);
                    n_err++;
                end
                if (release_clock !== want.release_clock)
                begin
                    $display("%0t: release_clock exp %0b got %0b", $time,
                             want.release_clock, release_clock);
                    n_err++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last exp %0b got %0b", $time, want.last, last);
                    n_err++;
                end
            end
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000)
        begin
            $display("%0t: watchdog expired, %0d items still expected", $time,
                     expected_q.size());
            $display("tb_i2c_slave_message_engine: done, errors");
            $finish;
        end
    end

    // hand one item to the engine; predict once it is taken
    task automatic send_item(msg_item_t it);
        if (!steady && $urandom_range(99) < 24)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push         <= 1'b1;
        cmd          <= it.cmd;
        start_seen   <= it.start_seen;
        stop_seen    <= it.stop_seen;
        byte_present <= it.byte_present;
        overrun      <= it.overrun;
        is_data      <= it.is_data;
        is_read      <= it.is_read;
        byte_in      <= it.byte_in;
        reply_last   <= it.reply_last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_results(it);
        n_items++;
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_threshold(logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_thresh = v;
    endtask

    function automatic msg_item_t bus_ev(logic st, logic sp, logic pr, logic ov,
                                         logic dt, logic rd, logic [7:0] b);
        msg_item_t it;
        it = '{cmd: 1'b0, start_seen: st, stop_seen: sp, byte_present: pr,
               overrun: ov, is_data: dt, is_read: rd, byte_in: b, reply_last: 1'b0};
        return it;
    endfunction

    function automatic msg_item_t reply_ld(logic [7:0] b, logic lst);
        msg_item_t it;
        it = '{cmd: 1'b1, start_seen: 1'b0, stop_seen: 1'b0, byte_present: 1'b0,
               overrun: 1'b0, is_data: 1'b0, is_read: 1'b0, byte_in: b,
               reply_last: lst};
        return it;
    endfunction

    function automatic res_item_t st_res(logic txv, logic [7:0] txb, logic rel);
        res_item_t r;
        r = '{kind: i2csme_pkg::KIND_STATUS, byte_out: 8'h00, tx_valid: txv,
              tx_byte: txb, release_clock: rel, last: 1'b0};
        return r;
    endfunction

    // one random transaction: mostly well-formed writes and reads, some noise
    task automatic random_transaction();
        int       pick;
        int       len;
        msg_item_t it;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            // master write: start, address, data bytes, stop
            if ($urandom_range(1))
                send_item(bus_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'($urandom)));
            else
            begin
                send_item(bus_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'($urandom)));
                send_item(bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'($urandom)));
            end
            // mostly short, sometimes long enough to overflow the store
            len = ($urandom_range(7) == 0) ? $urandom_range(26, 40) : $urandom_range(6);
            for (int i = 0; i < len; i++)
                send_item(bus_ev(1'b0, 1'b0, 1'b1, $urandom_range(60) == 0, 1'b1,
                                 1'($urandom), 8'($urandom)));
            if ($urandom_range(1))
                send_item(bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'($urandom)));
            else
                send_item(bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'($urandom), 1'($urandom),
                                 8'($urandom)));
        end
        else if (pick < 80)
        begin
            // master read: address, reply load, then transmit events
            if ($urandom_range(1))
                send_item(bus_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'($urandom)));
            else
            begin
                send_item(bus_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'($urandom)));
                send_item(bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'($urandom)));
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(32, 36) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_item(reply_ld(8'($urandom), i == len - 1));
            len = ($urandom_range(3) == 0) ? len + $urandom_range(1, 3) : len;
            for (int i = 0; i < len; i++)
                send_item(bus_ev(1'b0, 1'b0, 1'($urandom), 1'b0, 1'b1, 1'b1,
                                 8'($urandom)));
        end
        else
        begin
            // noise: any field, any value
            repeat ($urandom_range(1, 3))
            begin
                it = msg_item_t'(17'($urandom));
                it.cmd = ($urandom_range(3) == 0);
                send_item(it);
            end
        end
    endtask

    dir_row_t dir_tab[21];
    int       n_chk;

    initial
    begin
        // directed rows; typed status only where it is obvious
        dir_tab[0]  = '{bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
                        st_res(1'b0, 8'h00, 1'b0)};
        // overrun with a byte: clock released, report at threshold 1
        dir_tab[1]  = '{bus_ev(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'h5A), 1'b1,
                        st_res(1'b0, 8'h00, 1'b1)};
        dir_tab[2]  = '{bus_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'hA0), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[3]  = '{bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'hFF), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[4]  = '{bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[5]  = '{bus_ev(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[6]  = '{bus_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        // read address: byte consumed, clock kept, reply request follows
        dir_tab[7]  = '{bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'hA1), 1'b1,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[8]  = '{reply_ld(8'h11, 1'b0), 1'b1, st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[9]  = '{reply_ld(8'h22, 1'b1), 1'b1, st_res(1'b1, 8'h11, 1'b1)};
        dir_tab[10] = '{bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
                        st_res(1'b1, 8'h22, 1'b1)};
        dir_tab[11] = '{bus_ev(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b1,
                        st_res(1'b0, 8'h00, 1'b0)};
        // data byte with the start: address error
        dir_tab[12] = '{bus_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h33), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[13] = '{bus_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[14] = '{bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h44), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[15] = '{bus_ev(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[16] = '{bus_ev(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'hA0), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        dir_tab[17] = '{bus_ev(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'hA0), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        // address byte where data was due
        dir_tab[18] = '{bus_ev(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'hA2), 1'b0,
                        st_res(1'b0, 8'h00, 1'b0)};
        // load after transmission began restarts the reply store
        dir_tab[19] = '{reply_ld(8'h00, 1'b1), 1'b1, st_res(1'b1, 8'h00, 1'b1)};
        dir_tab[20] = '{reply_ld(8'hFF, 1'b1), 1'b1, st_res(1'b1, 8'hFF, 1'b1)};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        n_chk = 0;
        foreach (dir_tab[i])
        begin
            send_item(dir_tab[i].it);
            if (dir_tab[i].chk)
            begin
                n_chk++;
                // last depends on what follows the status; the queue check covers it
                typed_status = dir_tab[i].status;
                typed_status.last = pred_status.last;
                if (pred_status != typed_status)
                begin
                    $display("%0t: row %0d status exp %h got %h", $time, i,
                             typed_status, pred_status);
                    n_err++;
                end
            end
        end

        // random phases at several thresholds, extremes included
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: set_threshold(8'd255);
                1: set_threshold(8'd0);
                2: set_threshold(8'($urandom_range(2, 254)));
                default: set_threshold(8'd1);
            endcase
            steady = (ph == 2);
            while (n_items < 21 + 90 * (ph + 1))
                random_transaction();
            steady = 1'b0;
        end

        drain();
        if (expected_q.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, expected_q.size());
            n_err++;
        end
        $display("covered %0d items (%0d typed rows), thresholds 1, 255, 0, mid",
                 n_items, n_chk);
        $display("results seen: status %0d, message %0d, report %0d, request %0d",
                 n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
        if (n_err == 0)
            $display("tb_i2c_slave_message_engine: done, clean");
        else
            $display("tb_i2c_slave_message_engine: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/i2csme_pkg.sv
rtl/i2csme_front.sv
rtl/i2csme_back.sv
rtl/i2c_slave_message_engine.sv
tb/tb_i2c_slave_message_engine.sv
